// ===== hdl/rwcs_pkg.sv =====
// Shared types and constants for the raycast wall column shader.
package rwcs_pkg;

  localparam int ROW_W   = 12;
  localparam int COL_W   = 12;
  localparam int FACE_W  = 3;
  localparam int LEN_W   = 24;
  localparam int DIR_W   = 16;
  localparam int HGT_W   = 13;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 24;
  localparam int PITCH_W = 14;
  localparam int EYE_W   = 24;
  localparam int ORG_W   = 24;
  localparam int CFG_W   = 24;
  localparam int HC_W    = HGT_W + CELL_W;
  localparam int NSZ_W   = HC_W + 8;
  localparam int EYE_QW  = 24;
  localparam int V_W     = 41;
  localparam int FRAC_W  = 22;
  localparam int VH_W    = V_W - FRAC_W;
  localparam int GEO_W   = 27;

  localparam logic signed [GEO_W-1:0] GEO_ONE = 27'sd1;

  typedef enum logic [2:0] {
    CFG_SCREEN_HEIGHT = 3'd0,
    CFG_CELL_SIZE     = 3'd1,
    CFG_CEILING_COLOR = 3'd2,
    CFG_FLOOR_COLOR   = 3'd3,
    CFG_VIEW_PITCH    = 3'd4,
    CFG_EYE_HEIGHT    = 3'd5,
    CFG_ORIGIN_X      = 3'd6,
    CFG_ORIGIN_Y      = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_CEILING = 2'd1,
    KIND_WALL    = 2'd2,
    KIND_FLOOR   = 2'd3
  } pixel_kind_t;

  typedef struct packed {
    logic              valid;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [FACE_W-1:0] face;
    logic              lenz;
    logic              zsz;
    logic              ovf;
    logic              eneg;
  } row_side_t;

  typedef struct packed {
    logic              vneg;
    logic [FRAC_W-1:0] wl;
  } col_side_t;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pixel_kind_t      kind;
    logic [1:0]       tface;
    logic             mirror;
  } out_side_t;

endpackage

// ===== hdl/rwcs_delay.sv =====
// Enabled register delay line with synchronous clear.
module rwcs_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) pipe[i] <= '0;
    end else if (en) begin
      pipe[0] <= d;
      for (int i = 1; i < D; i++) pipe[i] <= pipe[i-1];
    end
  end

  assign q = pipe[D-1];

endmodule

// ===== hdl/rwcs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rwcs_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int EW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rin;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic [EW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign din = den_r[k-1];
      assign qin = quo_r[k-1];
    end

    assign trial = EW'(din) << (QW - 1 - k);
    assign ge    = EW'(rin) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? NW'(EW'(rin) - trial) : rin;
        quo_r[k] <= ge ? (qin | (QW'(1) << (QW - 1 - k))) : qin;
        den_r[k] <= din;
      end
    end
  end

  assign quo = quo_r[QW-1];
  assign rem = rem_r[QW-1][DW-1:0];

endmodule

// ===== hdl/raycast_wall_column_shader_core.sv =====
// Top level of the raycast wall column shader pipeline.
//
//   channel | signals                                       | direction
//   cfg     | cfg_write, cfg_index, cfg_data                | in
//   in      | in_valid, in_stall, screen_row .. dir_y       | in (stall out)
//   out     | out_valid, out_stall, out_row .. texel_row    | out (stall in)
//
// One transaction per clock sustained while the output is not stalled. The path
// runs through the 24-stage eye-height divider followed by the texel-row divider.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// A stalled output freezes every stage at once; in_stall follows out_stall
// while a result is held, so nothing is dropped or repeated.
module raycast_wall_column_shader_core #(
  parameter int TEX_SIZE = 64,
  parameter int MAX_ROWS = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [2:0]                           cfg_index,
  input  logic [rwcs_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rwcs_pkg::ROW_W-1:0]           screen_row,
  input  logic [rwcs_pkg::COL_W-1:0]           screen_column,
  input  logic [rwcs_pkg::FACE_W-1:0]          face,
  input  logic [rwcs_pkg::LEN_W-1:0]           ray_length,
  input  logic signed [rwcs_pkg::DIR_W-1:0]    dir_x,
  input  logic signed [rwcs_pkg::DIR_W-1:0]    dir_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rwcs_pkg::ROW_W-1:0]           out_row,
  output logic [rwcs_pkg::COL_W-1:0]           out_column,
  output logic [1:0]                           pixel_kind,
  output logic [rwcs_pkg::COLOR_W-1:0]         flat_color,
  output logic [1:0]                           texture_face,
  output logic [$clog2(TEX_SIZE)-1:0]          texel_column,
  output logic [$clog2(TEX_SIZE)-1:0]          texel_row
);

  localparam int TEXW     = $clog2(TEX_SIZE);
  localparam int SIZE_CAP = 16 * MAX_ROWS;
  localparam int SZQW     = $clog2(SIZE_CAP) + 1;
  localparam int CMPW     = (rwcs_pkg::NSZ_W > rwcs_pkg::LEN_W + SZQW) ?
                            rwcs_pkg::NSZ_W : rwcs_pkg::LEN_W + SZQW;
  localparam int SPW      = SZQW + 1;
  localparam int TNW      = SPW + TEXW;
  localparam int XW       = rwcs_pkg::CELL_W + TEXW;
  localparam int WLW      = rwcs_pkg::FRAC_W + TEXW;
  localparam int TC_DLY   = (rwcs_pkg::EYE_QW + 4) - (rwcs_pkg::VH_W + 1);
  localparam int GW       = rwcs_pkg::GEO_W;

  // configuration registers
  logic [rwcs_pkg::HGT_W-1:0]          screen_height;
  logic [rwcs_pkg::CELL_W-1:0]         cell_size;
  logic [rwcs_pkg::COLOR_W-1:0]        ceiling_color;
  logic [rwcs_pkg::COLOR_W-1:0]        floor_color;
  logic signed [rwcs_pkg::PITCH_W-1:0] view_pitch;
  logic signed [rwcs_pkg::EYE_W-1:0]   eye_height;
  logic [rwcs_pkg::ORG_W-1:0]          origin_x;
  logic [rwcs_pkg::ORG_W-1:0]          origin_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= 13'd480;
      cell_size     <= 16'd64;
      ceiling_color <= '0;
      floor_color   <= '0;
      view_pitch    <= '0;
      eye_height    <= '0;
      origin_x      <= '0;
      origin_y      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rwcs_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[12:0];
        rwcs_pkg::CFG_CELL_SIZE:     cell_size     <= cfg_data[15:0];
        rwcs_pkg::CFG_CEILING_COLOR: ceiling_color <= cfg_data;
        rwcs_pkg::CFG_FLOOR_COLOR:   floor_color   <= cfg_data;
        rwcs_pkg::CFG_VIEW_PITCH:    view_pitch    <= cfg_data[13:0];
        rwcs_pkg::CFG_EYE_HEIGHT:    eye_height    <= cfg_data;
        rwcs_pkg::CFG_ORIGIN_X:      origin_x      <= cfg_data;
        rwcs_pkg::CFG_ORIGIN_Y:      origin_y      <= cfg_data;
      endcase
    end
  end

  logic                       adv;
  logic [rwcs_pkg::HGT_W-1:0] h;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;
  assign h = (screen_height > rwcs_pkg::HGT_W'(MAX_ROWS)) ?
             rwcs_pkg::HGT_W'(MAX_ROWS) : screen_height;

  // stage 1: products
  logic                          s1_valid;
  logic [rwcs_pkg::ROW_W-1:0]    s1_row;
  logic [rwcs_pkg::COL_W-1:0]    s1_col;
  logic [rwcs_pkg::FACE_W-1:0]   s1_face;
  logic [rwcs_pkg::LEN_W-1:0]    s1_len;
  logic                          s1_eneg;
  logic [rwcs_pkg::EYE_W-1:0]    s1_eabs;
  logic [rwcs_pkg::HC_W-1:0]     s1_hc;
  logic signed [rwcs_pkg::V_W-1:0] s1_prod;
  logic [rwcs_pkg::ORG_W-1:0]    s1_orig;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_row  <= screen_row;
      s1_col  <= screen_column;
      s1_face <= face;
      s1_len  <= ray_length;
      s1_eneg <= eye_height[rwcs_pkg::EYE_W-1];
      s1_eabs <= eye_height[rwcs_pkg::EYE_W-1] ? rwcs_pkg::EYE_W'(-eye_height) :
                 rwcs_pkg::EYE_W'(eye_height);
      s1_hc   <= rwcs_pkg::HC_W'(h) * rwcs_pkg::HC_W'(cell_size);
      s1_prod <= (face[0] ? dir_x : dir_y) * $signed({1'b0, ray_length});
      s1_orig <= face[0] ? origin_x : origin_y;
    end
  end

  // stage 2: hit coordinate, saturation check, divider operands
  logic signed [rwcs_pkg::V_W-1:0]  v_c;
  logic signed [rwcs_pkg::VH_W-1:0] vh_c;
  logic [CMPW-1:0]                  ovf_a, ovf_b;

  assign v_c   = $signed({{(rwcs_pkg::V_W - rwcs_pkg::ORG_W - 14){1'b0}}, s1_orig, 14'b0})
                 + s1_prod;
  assign vh_c  = v_c[rwcs_pkg::V_W-1:rwcs_pkg::FRAC_W];
  assign ovf_a = CMPW'({s1_hc, 8'b0});
  assign ovf_b = CMPW'(s1_len) << SZQW;

  rwcs_pkg::row_side_t          s2_rs;
  rwcs_pkg::col_side_t          s2_cs;
  logic [rwcs_pkg::EYE_W-1:0]   s2_eabs;
  logic [rwcs_pkg::LEN_W-1:0]   s2_len;
  logic [rwcs_pkg::NSZ_W-1:0]   s2_nsz;
  logic [rwcs_pkg::VH_W-1:0]    s2_vhabs;

  always_ff @(posedge clk) begin
    if (rst) s2_rs.valid <= 1'b0;
    else if (adv) s2_rs.valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_rs.row  <= s1_row;
      s2_rs.col  <= s1_col;
      s2_rs.face <= s1_face;
      s2_rs.lenz <= (s1_len == '0);
      s2_rs.zsz  <= (s1_len == '0) || (cell_size == '0);
      s2_rs.ovf  <= ovf_a >= ovf_b;
      s2_rs.eneg <= s1_eneg;
      s2_cs.vneg <= v_c[rwcs_pkg::V_W-1];
      s2_cs.wl   <= v_c[rwcs_pkg::FRAC_W-1:0];
      s2_eabs    <= s1_eabs;
      s2_len     <= s1_len;
      s2_nsz     <= {s1_hc, 8'b0};
      s2_vhabs   <= vh_c[rwcs_pkg::VH_W-1] ? rwcs_pkg::VH_W'(-vh_c) :
                    rwcs_pkg::VH_W'(vh_c);
    end
  end

  // dividers: eye shift, wall size, hit coordinate modulo
  logic [rwcs_pkg::EYE_QW-1:0] eq;
  logic [rwcs_pkg::LEN_W-1:0]  er;
  logic [SZQW-1:0]             szq, szq_d;
  logic [rwcs_pkg::CELL_W-1:0] mr;

  rwcs_div #(.NW(rwcs_pkg::EYE_W), .DW(rwcs_pkg::LEN_W), .QW(rwcs_pkg::EYE_QW)) u_eye_div (
    .clk(clk), .en(adv), .num(s2_eabs), .den(s2_len), .quo(eq), .rem(er)
  );

  rwcs_div #(.NW(rwcs_pkg::NSZ_W), .DW(rwcs_pkg::LEN_W), .QW(SZQW)) u_size_div (
    .clk(clk), .en(adv), .num(s2_nsz), .den(s2_len), .quo(szq), .rem()
  );

  rwcs_delay #(.W(SZQW), .D(rwcs_pkg::EYE_QW - SZQW)) u_size_dly (
    .clk(clk), .rst(rst), .en(adv), .d(szq), .q(szq_d)
  );

  rwcs_div #(.NW(rwcs_pkg::VH_W), .DW(rwcs_pkg::CELL_W), .QW(rwcs_pkg::VH_W)) u_mod_div (
    .clk(clk), .en(adv), .num(s2_vhabs), .den(cell_size), .quo(), .rem(mr)
  );

  rwcs_pkg::row_side_t rs_q;
  rwcs_pkg::col_side_t cs_q;

  rwcs_delay #(.W($bits(rwcs_pkg::row_side_t)), .D(rwcs_pkg::EYE_QW)) u_row_dly (
    .clk(clk), .rst(rst), .en(adv), .d(s2_rs), .q(rs_q)
  );

  rwcs_delay #(.W($bits(rwcs_pkg::col_side_t)), .D(rwcs_pkg::VH_W)) u_col_dly (
    .clk(clk), .rst(rst), .en(adv), .d(s2_cs), .q(cs_q)
  );

  // column path: floor modulo, then scale to texture width
  logic [rwcs_pkg::CELL_W-1:0] wh_c;
  logic [XW-1:0]               fx_x;
  logic [TEXW-1:0]             tcq, tcq_d;

  assign wh_c = (cs_q.vneg && mr != '0) ? cell_size - mr : mr;

  always_ff @(posedge clk) begin
    if (adv) begin
      fx_x <= XW'(wh_c) * XW'(TEX_SIZE) +
              XW'((WLW'(cs_q.wl) * WLW'(TEX_SIZE)) >> rwcs_pkg::FRAC_W);
    end
  end

  rwcs_div #(.NW(XW), .DW(rwcs_pkg::CELL_W), .QW(TEXW)) u_tc_div (
    .clk(clk), .en(adv), .num(fx_x), .den(cell_size), .quo(tcq), .rem()
  );

  rwcs_delay #(.W(TEXW), .D(TC_DLY)) u_tc_dly (
    .clk(clk), .rst(rst), .en(adv), .d(tcq), .q(tcq_d)
  );

  // row path J1: saturated size, floor of eye shift
  localparam logic signed [GW-1:0] GEO_ONE_C = rwcs_pkg::GEO_ONE;

  logic [SZQW-1:0]        sz_c;
  logic signed [GW-1:0]   q0e, fq_c;
  logic                   rnz_c;

  assign q0e   = $signed(GW'(eq));
  assign rnz_c = !rs_q.lenz && (er != '0);

  always_comb begin
    if (rs_q.zsz) sz_c = '0;
    else if (rs_q.ovf || szq_d > SZQW'(SIZE_CAP)) sz_c = SZQW'(SIZE_CAP);
    else sz_c = szq_d;
    if (rs_q.lenz) fq_c = '0;
    else if (!rs_q.eneg) fq_c = q0e;
    else if (rnz_c) fq_c = -q0e - GEO_ONE_C;
    else fq_c = -q0e;
  end

  rwcs_pkg::row_side_t  j1_rs, j2_rs, j3_rs;
  logic [SZQW-1:0]      j1_sz;
  logic signed [GW-1:0] j1_fq;
  logic                 j1_rnz, j2_rnz;

  always_ff @(posedge clk) begin
    if (rst) begin
      j1_rs.valid <= 1'b0;
      j2_rs.valid <= 1'b0;
      j3_rs.valid <= 1'b0;
    end else if (adv) begin
      j1_rs.valid <= rs_q.valid;
      j2_rs.valid <= j1_rs.valid;
      j3_rs.valid <= j2_rs.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j1_rs.row  <= rs_q.row;   j1_rs.col  <= rs_q.col;   j1_rs.face <= rs_q.face;
      j1_rs.lenz <= rs_q.lenz;  j1_rs.zsz  <= rs_q.zsz;   j1_rs.ovf  <= rs_q.ovf;
      j1_rs.eneg <= rs_q.eneg;
      j1_sz  <= sz_c;
      j1_fq  <= fq_c;
      j1_rnz <= rnz_c;
    end
  end

  // J2: span edges with pitch and floor shift
  logic signed [GW-1:0] h_ext, sz_ext, hs_c, top_c, bot_c, p_ext;
  logic signed [GW-1:0] j2_top, j2_bot;

  assign h_ext  = $signed(GW'(h));
  assign sz_ext = $signed(GW'(j1_sz));
  assign p_ext  = GW'(view_pitch);
  assign hs_c   = h_ext - sz_ext;
  // halve toward zero
  assign top_c  = (hs_c < 0) ? ((hs_c + GEO_ONE_C) >>> 1) : (hs_c >>> 1);
  assign bot_c  = (h_ext + sz_ext) >>> 1;

  always_ff @(posedge clk) begin
    if (adv) begin
      j2_rs.row  <= j1_rs.row;  j2_rs.col  <= j1_rs.col;  j2_rs.face <= j1_rs.face;
      j2_rs.lenz <= j1_rs.lenz; j2_rs.zsz  <= j1_rs.zsz;  j2_rs.ovf  <= j1_rs.ovf;
      j2_rs.eneg <= j1_rs.eneg;
      j2_top <= top_c + p_ext + j1_fq;
      j2_bot <= bot_c + p_ext + j1_fq;
      j2_rnz <= j1_rnz;
    end
  end

  // J3: round negative inexact results toward zero
  logic signed [GW-1:0] j3_start, j3_end;

  always_ff @(posedge clk) begin
    if (adv) begin
      j3_rs.row  <= j2_rs.row;  j3_rs.col  <= j2_rs.col;  j3_rs.face <= j2_rs.face;
      j3_rs.lenz <= j2_rs.lenz; j3_rs.zsz  <= j2_rs.zsz;  j3_rs.ovf  <= j2_rs.ovf;
      j3_rs.eneg <= j2_rs.eneg;
      j3_start <= (j2_top < 0 && j2_rnz) ? j2_top + GEO_ONE_C : j2_top;
      j3_end   <= (j2_bot < 0 && j2_rnz) ? j2_bot + GEO_ONE_C : j2_bot;
    end
  end

  // J4: classify and set up the texel row division
  rwcs_pkg::pixel_kind_t kind_c;
  logic signed [GW-1:0]  r_ext;
  logic                  on_c;
  rwcs_pkg::out_side_t   j4_os, os_q;
  logic [TNW-1:0]        j4_tnum;
  logic [SPW-1:0]        j4_span;
  logic [TEXW-1:0]       trq;

  assign r_ext = $signed(GW'(j3_rs.row));
  assign on_c  = (j3_rs.face >= 3'd1) && (j3_rs.face <= 3'd4) &&
                 (rwcs_pkg::HGT_W'(j3_rs.row) < h);

  always_comb begin
    priority if (!on_c) kind_c = rwcs_pkg::KIND_NONE;
    else if (r_ext < j3_start) kind_c = rwcs_pkg::KIND_CEILING;
    else if (r_ext < j3_end) kind_c = rwcs_pkg::KIND_WALL;
    else kind_c = rwcs_pkg::KIND_FLOOR;
  end

  always_ff @(posedge clk) begin
    if (rst) j4_os.valid <= 1'b0;
    else if (adv) j4_os.valid <= j3_rs.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j4_os.row    <= j3_rs.row;
      j4_os.col    <= j3_rs.col;
      j4_os.kind   <= kind_c;
      j4_os.tface  <= 2'(j3_rs.face - 3'd1);
      j4_os.mirror <= (j3_rs.face == 3'd1) || (j3_rs.face == 3'd4);
      j4_tnum      <= TNW'(SPW'(r_ext - j3_start)) * TNW'(TEX_SIZE);
      j4_span      <= SPW'(j3_end - j3_start);
    end
  end

  rwcs_div #(.NW(TNW), .DW(SPW), .QW(TEXW)) u_tr_div (
    .clk(clk), .en(adv), .num(j4_tnum), .den(j4_span), .quo(trq), .rem()
  );

  rwcs_delay #(.W($bits(rwcs_pkg::out_side_t)), .D(TEXW)) u_out_dly (
    .clk(clk), .rst(rst), .en(adv), .d(j4_os), .q(os_q)
  );

  // output register
  logic is_wall;
  assign is_wall = (os_q.kind == rwcs_pkg::KIND_WALL);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= os_q.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row      <= os_q.row;
      out_column   <= os_q.col;
      pixel_kind   <= os_q.kind;
      flat_color   <= (os_q.kind == rwcs_pkg::KIND_CEILING) ? ceiling_color :
                      (os_q.kind == rwcs_pkg::KIND_FLOOR) ? floor_color : '0;
      texture_face <= is_wall ? os_q.tface : 2'd0;
      texel_column <= !is_wall ? '0 :
                      os_q.mirror ? TEXW'(TEX_SIZE - 1) - tcq_d : tcq_d;
      texel_row    <= is_wall ? trq : '0;
    end
  end

endmodule
